>>> rtl/plr_pkg.sv
package plr_pkg;

	// Geometry of the point store.
	localparam int MAX_POINTS = 16;
	localparam int CHANNELS = 4;
	localparam int PTR_W = $clog2(MAX_POINTS);
	localparam int NCNT_W = PTR_W + 1;

	// Sample grid: index i stands for abscissa i / SAMPLE_COUNT.
	localparam int SAMPLE_COUNT = 256;
	localparam int ONE_Q16 = 65536;
	localparam int STEP = ONE_Q16 / SAMPLE_COUNT;

	// Field widths.
	localparam int X_W = 17;
	localparam int Y_W = 18;
	localparam int IDX_W = 8;
	localparam int CNT_W = 5;
	localparam int CH_W = 2;
	localparam int SLOT_W = 4;
	localparam int OUT_W = 8;
	localparam int FRAC_W = 16;

	// Datapath widths.
	localparam int D_W = X_W + 1;
	localparam int DY_W = Y_W + 1;
	localparam int P0_W = Y_W + X_W + 1;
	localparam int P1_W = DY_W + D_W;
	localparam int SUM_W = P1_W + 1;
	localparam int NUM_W = SUM_W + OUT_W;
	localparam int REM_W = X_W + FRAC_W + OUT_W;

	// One quotient bit per divider stage.
	localparam int DIV_STEPS = OUT_W;
	// Search, read, four interpolation stages, classify, then the divider.
	localparam int PIPE_DEPTH = 7 + DIV_STEPS;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam int CH_RED = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE = 2;
	localparam int CH_ALPHA = 3;

	localparam logic [CNT_W-1:0] COUNT_RST [CHANNELS] = '{5'd3, 5'd3, 5'd3, 5'd2};

	typedef struct packed {
		logic signed [Y_W-1:0] y;
		logic [X_W-1:0] x;
	} point_t;

	// The two end points of the chosen segment.
	typedef struct packed {
		logic vld;
		point_t p0;
		point_t p1;
	} pair_t;

	// Fraction num / (den * 2^16) that still has to be floored and clamped.
	typedef struct packed {
		logic vld;
		logic signed [NUM_W-1:0] num;
		logic [X_W-1:0] den;
	} frac_t;

	function automatic logic [X_W-1:0] sample_abscissa(input logic [IDX_W-1:0] idx);
		return X_W'(32'(idx) * STEP);
	endfunction

endpackage

>>> rtl/plr_point_store.sv
module plr_point_store (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [plr_pkg::SLOT_W-1:0] wr_slot,
	input plr_pkg::point_t wr_point,
	input logic rd_en,
	input logic [plr_pkg::IDX_W-1:0] rd_index,
	input logic [plr_pkg::CNT_W-1:0] point_count,
	output plr_pkg::pair_t pair_s2
);

	// Abscissas as a row of flops for the parallel search, full points in a RAM.
	logic [plr_pkg::X_W-1:0] xrow_q [plr_pkg::MAX_POINTS];
	plr_pkg::point_t mem [plr_pkg::MAX_POINTS];

	logic wr_ok;
	logic [plr_pkg::PTR_W-1:0] wr_addr;
	logic [plr_pkg::X_W-1:0] target;
	logic [plr_pkg::NCNT_W-1:0] n_eff;
	logic [plr_pkg::PTR_W-1:0] last;
	logic [plr_pkg::MAX_POINTS-2:0] hit;
	logic [plr_pkg::MAX_POINTS-2:0] first_hit;
	logic [plr_pkg::PTR_W-1:0] enc;
	logic [plr_pkg::PTR_W-1:0] seg;

	logic vld_s1;
	logic [plr_pkg::PTR_W-1:0] seg_s1;
	logic vld_s2;
	plr_pkg::point_t p0_s2;
	plr_pkg::point_t p1_s2;

	assign wr_ok = wr_en && (32'(wr_slot) < plr_pkg::MAX_POINTS);
	assign wr_addr = plr_pkg::PTR_W'(wr_slot);
	assign target = plr_pkg::sample_abscissa(rd_index);

	always_comb begin
		if (point_count < plr_pkg::CNT_W'(2)) begin
			n_eff = plr_pkg::NCNT_W'(2);
		end else if (32'(point_count) > plr_pkg::MAX_POINTS) begin
			n_eff = plr_pkg::NCNT_W'(plr_pkg::MAX_POINTS);
		end else begin
			n_eff = plr_pkg::NCNT_W'(point_count);
		end
		last = plr_pkg::PTR_W'(n_eff - plr_pkg::NCNT_W'(2));
	end

	// Segment k qualifies when it precedes the last segment and its end reaches the target.
	always_comb begin
		for (int k = 0; k < plr_pkg::MAX_POINTS - 1; k++) begin
			hit[k] = (plr_pkg::PTR_W'(k) < last) && (xrow_q[k+1] >= target);
		end
		first_hit = hit & (~hit + 1'b1);
		enc = '0;
		for (int k = 0; k < plr_pkg::MAX_POINTS - 1; k++) begin
			if (first_hit[k]) begin
				enc = enc | plr_pkg::PTR_W'(k);
			end
		end
		seg = (hit == '0) ? last : enc;
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			xrow_q[wr_addr] <= wr_point.x;
			mem[wr_addr] <= wr_point;
		end
	end

	always_ff @(posedge clk) begin
		seg_s1 <= seg;
		p0_s2 <= mem[seg_s1];
		p1_s2 <= mem[seg_s1 + plr_pkg::PTR_W'(1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
		end
	end

	assign pair_s2 = '{vld: vld_s2, p0: p0_s2, p1: p1_s2};

endmodule

>>> rtl/plr_lerp.sv
module plr_lerp (
	input logic clk,
	input logic arst_n,
	input plr_pkg::pair_t pair_s2,
	input logic [plr_pkg::IDX_W-1:0] idx_s2,
	output plr_pkg::frac_t frac_s6
);

	logic signed [plr_pkg::D_W-1:0] x0s;
	logic signed [plr_pkg::D_W-1:0] x1s;
	logic signed [plr_pkg::D_W-1:0] ts;
	logic signed [plr_pkg::D_W-1:0] d_fwd;
	logic signed [plr_pkg::D_W-1:0] d_rev;
	logic signed [plr_pkg::D_W-1:0] m_fwd;
	logic signed [plr_pkg::D_W-1:0] m_rev;
	logic flip;

	logic vld_s3, vld_s4, vld_s5, vld_s6;
	logic [plr_pkg::X_W-1:0] dabs_s3;
	logic signed [plr_pkg::D_W-1:0] m_s3;
	logic signed [plr_pkg::DY_W-1:0] dy_s3;
	logic signed [plr_pkg::Y_W-1:0] y0_s3;
	logic zero_s3;

	logic signed [plr_pkg::P0_W-1:0] p0_s4;
	logic signed [plr_pkg::P1_W-1:0] p1_s4;
	logic signed [plr_pkg::Y_W-1:0] y0_s4;
	logic zero_s4;
	logic [plr_pkg::X_W-1:0] den_s4;

	logic signed [plr_pkg::SUM_W-1:0] sum_s5;
	logic [plr_pkg::X_W-1:0] den_s5;

	logic signed [plr_pkg::NUM_W-1:0] num_s6;
	logic [plr_pkg::X_W-1:0] den_s6;

	// Both directions are formed at once so that the sign flip is only a select.
	always_comb begin
		x0s = signed'({1'b0, pair_s2.p0.x});
		x1s = signed'({1'b0, pair_s2.p1.x});
		ts = signed'({1'b0, plr_pkg::sample_abscissa(idx_s2)});
		d_fwd = x1s - x0s;
		d_rev = x0s - x1s;
		m_fwd = ts - x0s;
		m_rev = x0s - ts;
		flip = d_fwd[plr_pkg::D_W-1];
	end

	always_ff @(posedge clk) begin
		dabs_s3 <= flip ? d_rev[plr_pkg::X_W-1:0] : d_fwd[plr_pkg::X_W-1:0];
		m_s3 <= flip ? m_rev : m_fwd;
		dy_s3 <= plr_pkg::DY_W'(pair_s2.p1.y) - plr_pkg::DY_W'(pair_s2.p0.y);
		y0_s3 <= pair_s2.p0.y;
		zero_s3 <= (pair_s2.p0.x == pair_s2.p1.x);

		p0_s4 <= y0_s3 * signed'({1'b0, dabs_s3});
		p1_s4 <= dy_s3 * m_s3;
		y0_s4 <= y0_s3;
		zero_s4 <= zero_s3;
		den_s4 <= zero_s3 ? plr_pkg::X_W'(1) : dabs_s3;

		// A zero-width segment gives its start value over a unit width.
		sum_s5 <= zero_s4 ? plr_pkg::SUM_W'(y0_s4)
			: plr_pkg::SUM_W'(p0_s4) + plr_pkg::SUM_W'(p1_s4);
		den_s5 <= den_s4;

		// Times 255, written as 256x - x.
		num_s6 <= (plr_pkg::NUM_W'(sum_s5) <<< plr_pkg::OUT_W) - plr_pkg::NUM_W'(sum_s5);
		den_s6 <= den_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s3 <= pair_s2.vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign frac_s6 = '{vld: vld_s6, num: num_s6, den: den_s6};

endmodule

>>> rtl/plr_divider.sv
module plr_divider (
	input logic clk,
	input logic arst_n,
	input plr_pkg::frac_t frac_s6,
	output logic vld_out,
	output logic [plr_pkg::OUT_W-1:0] value
);

	logic neg;
	logic hi;
	logic [plr_pkg::NUM_W-1:0] limit;

	// Index 0 is the classify stage, index i the result of quotient step i.
	logic vld_s [plr_pkg::DIV_STEPS+1];
	logic done_s [plr_pkg::DIV_STEPS+1];
	logic [plr_pkg::REM_W-1:0] rem_s [plr_pkg::DIV_STEPS+1];
	logic [plr_pkg::OUT_W-1:0] quo_s [plr_pkg::DIV_STEPS+1];
	logic [plr_pkg::X_W-1:0] den_s [plr_pkg::DIV_STEPS+1];

	// Negative values clamp to zero, and anything at or past 256 times the
	// denominator clamps to full scale; only the rest needs quotient bits.
	always_comb begin
		limit = plr_pkg::NUM_W'(frac_s6.den) << (plr_pkg::FRAC_W + plr_pkg::OUT_W);
		neg = frac_s6.num[plr_pkg::NUM_W-1];
		hi = !neg && (unsigned'(frac_s6.num) >= limit);
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= frac_s6.num[plr_pkg::REM_W-1:0];
		quo_s[0] <= hi ? '1 : '0;
		done_s[0] <= neg || hi;
		den_s[0] <= frac_s6.den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= frac_s6.vld;
		end
	end

	for (genvar i = 0; i < plr_pkg::DIV_STEPS; i++) begin : g_step
		localparam int SH = plr_pkg::FRAC_W + plr_pkg::DIV_STEPS - 1 - i;
		logic [plr_pkg::REM_W:0] cand;
		logic take;

		assign cand = {1'b0, rem_s[i]} - {1'b0, plr_pkg::REM_W'(den_s[i]) << SH};
		assign take = !done_s[i] && !cand[plr_pkg::REM_W];

		always_ff @(posedge clk) begin
			rem_s[i+1] <= take ? cand[plr_pkg::REM_W-1:0] : rem_s[i];
			quo_s[i+1] <= take ? (quo_s[i] | (plr_pkg::OUT_W'(1) << (plr_pkg::DIV_STEPS - 1 - i)))
				: quo_s[i];
			done_s[i+1] <= done_s[i];
			den_s[i+1] <= den_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	assign vld_out = vld_s[plr_pkg::DIV_STEPS];
	assign value = quo_s[plr_pkg::DIV_STEPS];

endmodule

>>> rtl/piecewise_linear_rgba_ramp.sv
// Piecewise-linear RGBA color ramp. Four polylines of up to 16 control points
// (red, green, blue, alpha) are loaded one point per request with operation
// low; a request with operation high samples all four at abscissa
// sample_index/256 and returns four 8-bit values, each y*255 floored and
// clamped to 0..255, along with the index. busy never rises: a request of
// either kind is taken in every cycle, and a point loaded in one cycle is seen
// by a sample taken in the next. Each sample result appears on result_strobe
// once it has passed the whole pipeline, for one cycle, in request order; the
// receiver cannot stall it. The depth comes from the segment search (one
// stage), the registered read of the point RAM (one stage), four stages of
// interpolation arithmetic with 18x18 and 19x18 multiplies, a clamp stage, and
// a restoring divider that settles one result bit per stage (eight stages).
// Point-count registers may be written only while no sample is in flight;
// counts below 2 act as 2 and counts above 16 act as 16. Reading a point that
// was never loaded gives an undefined value.
module piecewise_linear_rgba_ramp (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [0:0] operation,
	input logic [plr_pkg::CH_W-1:0] channel,
	input logic [plr_pkg::SLOT_W-1:0] slot,
	input logic [plr_pkg::X_W-1:0] point_x,
	input logic signed [plr_pkg::Y_W-1:0] point_y,
	input logic [plr_pkg::IDX_W-1:0] sample_index,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [plr_pkg::CH_W-1:0] cfg_index,
	input logic [plr_pkg::CNT_W-1:0] cfg_data,
	output logic result_strobe,
	output logic [plr_pkg::OUT_W-1:0] red,
	output logic [plr_pkg::OUT_W-1:0] green,
	output logic [plr_pkg::OUT_W-1:0] blue,
	output logic [plr_pkg::OUT_W-1:0] alpha,
	output logic [plr_pkg::IDX_W-1:0] sample_echo
);

	logic accept;
	logic load_acc;
	logic sample_acc;
	plr_pkg::point_t wr_point;

	// Point counts, one register per channel.
	logic [plr_pkg::CNT_W-1:0] count_q [plr_pkg::CHANNELS];

	// The sample index rides alongside the pipeline; entry k is stage k+1.
	logic [plr_pkg::IDX_W-1:0] idx_s [plr_pkg::PIPE_DEPTH];

	logic [plr_pkg::CHANNELS-1:0] ch_vld;
	logic [plr_pkg::OUT_W-1:0] ch_value [plr_pkg::CHANNELS];

	// Every stage advances each cycle, so the block never pushes back.
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	assign accept = start && !busy;
	assign load_acc = accept && (operation == plr_pkg::OP_LOAD);
	assign sample_acc = accept && (operation == plr_pkg::OP_SAMPLE);
	assign wr_point = '{y: point_y, x: point_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < plr_pkg::CHANNELS; c++) begin
				count_q[c] <= plr_pkg::COUNT_RST[c];
			end
		end else if (cfg_valid && cfg_ready && (32'(cfg_index) < plr_pkg::CHANNELS)) begin
			count_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		idx_s[0] <= sample_index;
		for (int k = 1; k < plr_pkg::PIPE_DEPTH; k++) begin
			idx_s[k] <= idx_s[k-1];
		end
	end

	// One search, interpolation and divide path per color channel.
	for (genvar c = 0; c < plr_pkg::CHANNELS; c++) begin : g_ch
		plr_pkg::pair_t pair_s2;
		plr_pkg::frac_t frac_s6;

		plr_point_store u_store (
			.clk(clk),
			.arst_n(arst_n),
			.wr_en(load_acc && (channel == plr_pkg::CH_W'(c))),
			.wr_slot(slot),
			.wr_point(wr_point),
			.rd_en(sample_acc),
			.rd_index(sample_index),
			.point_count(count_q[c]),
			.pair_s2(pair_s2)
		);

		plr_lerp u_lerp (
			.clk(clk),
			.arst_n(arst_n),
			.pair_s2(pair_s2),
			.idx_s2(idx_s[1]),
			.frac_s6(frac_s6)
		);

		plr_divider u_div (
			.clk(clk),
			.arst_n(arst_n),
			.frac_s6(frac_s6),
			.vld_out(ch_vld[c]),
			.value(ch_value[c])
		);
	end

	assign result_strobe = ch_vld[plr_pkg::CH_RED];
	assign red = ch_value[plr_pkg::CH_RED];
	assign green = ch_value[plr_pkg::CH_GREEN];
	assign blue = ch_value[plr_pkg::CH_BLUE];
	assign alpha = ch_value[plr_pkg::CH_ALPHA];
	assign sample_echo = idx_s[plr_pkg::PIPE_DEPTH-1];

`ifndef SYNTH
	a_strobe_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(sample_acc, plr_pkg::PIPE_DEPTH))
		else $error("result strobe without a sample request at the pipeline depth");

	a_channels_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_vld == '0) || (ch_vld == '1))
		else $error("channel pipelines out of step");

	a_echo_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (sample_echo == $past(sample_index, plr_pkg::PIPE_DEPTH)))
		else $error("echoed index does not match its request");
`endif

endmodule

>>> tb/plr_ramp_checker.sv
`timescale 1ns / 1ps

module plr_ramp_checker
	import plr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [0:0] operation,
	input logic [CH_W-1:0] channel,
	input logic [SLOT_W-1:0] slot,
	input logic [X_W-1:0] point_x,
	input logic signed [Y_W-1:0] point_y,
	input logic [IDX_W-1:0] sample_index,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CH_W-1:0] cfg_index,
	input logic [CNT_W-1:0] cfg_data,
	input logic result_strobe,
	input logic [OUT_W-1:0] red,
	input logic [OUT_W-1:0] green,
	input logic [OUT_W-1:0] blue,
	input logic [OUT_W-1:0] alpha,
	input logic [IDX_W-1:0] sample_echo,
	output int error_count,
	output int pending_count
);

	typedef struct {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
		logic [OUT_W-1:0] alpha;
		logic [IDX_W-1:0] echo;
	} pixel_t;

	localparam logic [CNT_W-1:0] POINTS_AFTER_RESET [CHANNELS] = '{5'd3, 5'd3, 5'd3, 5'd2};
	localparam longint FULL_SCALE = 255;

	logic [X_W-1:0] knot_x [CHANNELS*MAX_POINTS];
	logic signed [Y_W-1:0] knot_y [CHANNELS*MAX_POINTS];
	logic [CNT_W-1:0] points_in_use [CHANNELS] = POINTS_AFTER_RESET;
	pixel_t expected_pixels [$];
	int mismatches = 0;

	assign error_count = mismatches;

	function automatic longint floor_quotient(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	// Value of one polyline at abscissa idx/256, scaled to 0..255.
	function automatic logic [OUT_W-1:0] channel_level(int ch, logic [IDX_W-1:0] idx);
		int n;
		int seg;
		int base;
		longint xs, x0, x1, y0, y1, num, den, lvl;
		n = points_in_use[ch];
		if (n < 2)
			n = 2;
		if (n > MAX_POINTS)
			n = MAX_POINTS;
		base = ch * MAX_POINTS;
		xs = longint'(idx) * ONE_Q16;
		// First segment whose end reaches the sample, else the last one.
		seg = n - 2;
		for (int k = n - 3; k >= 0; k--) begin
			if (longint'(knot_x[base + k + 1]) * SAMPLE_COUNT >= xs)
				seg = k;
		end
		x0 = longint'(knot_x[base + seg]) * SAMPLE_COUNT;
		x1 = longint'(knot_x[base + seg + 1]) * SAMPLE_COUNT;
		y0 = longint'(knot_y[base + seg]);
		y1 = longint'(knot_y[base + seg + 1]);
		den = x1 - x0;
		num = xs - x0;
		if (den == 0) begin
			lvl = floor_quotient(y0 * FULL_SCALE, ONE_Q16);
		end else begin
			if (den < 0) begin
				den = -den;
				num = -num;
			end
			lvl = floor_quotient((y0 * den + (y1 - y0) * num) * FULL_SCALE, den * ONE_Q16);
		end
		if (lvl < 0)
			lvl = 0;
		if (lvl > FULL_SCALE)
			lvl = FULL_SCALE;
		return OUT_W'(lvl);
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_level(string field, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want,
			logic [IDX_W-1:0] idx);
		if (got !== want)
			report_mismatch($sformatf("sample %0d: %s is %0d, expected %0d", idx, field, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			points_in_use = POINTS_AFTER_RESET;
			expected_pixels.delete();
			pending_count <= 0;
		end else begin
			// Results are checked first: one landing now belongs to an older request.
			if (result_strobe) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("result for sample %0d with nothing pending",
						sample_echo));
				end else begin
					want = expected_pixels.pop_front();
					check_level("sample_echo", sample_echo, want.echo, want.echo);
					check_level("red", red, want.red, want.echo);
					check_level("green", green, want.green, want.echo);
					check_level("blue", blue, want.blue, want.echo);
					check_level("alpha", alpha, want.alpha, want.echo);
				end
			end
			if (cfg_valid && cfg_ready)
				points_in_use[cfg_index] = cfg_data;
			if (start && !busy) begin
				if (operation == OP_LOAD) begin
					knot_x[int'(channel) * MAX_POINTS + int'(slot)] = point_x;
					knot_y[int'(channel) * MAX_POINTS + int'(slot)] = point_y;
				end else begin
					want.red = channel_level(CH_RED, sample_index);
					want.green = channel_level(CH_GREEN, sample_index);
					want.blue = channel_level(CH_BLUE, sample_index);
					want.alpha = channel_level(CH_ALPHA, sample_index);
					want.echo = sample_index;
					expected_pixels.insert(expected_pixels.size(), want);
				end
			end
			pending_count <= expected_pixels.size();
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// Top of the ramp testbench. It only generates requests and configuration
// writes and prints the verdict; all prediction and comparison lives in the
// checker instantiated next to the block.
module tb;
	import plr_pkg::*;

	// Random requests issued after the directed part.
	localparam int ITEM_TARGET = 1800;
	// Longest pause the sender takes before a request.
	localparam int GAP_MAX = 19;
	// Cycles allowed after the last result before the count registers are touched
	// or the run ends; covers the pipeline depth with some margin.
	localparam int SETTLE_CYCLES = PIPE_DEPTH + 8;
	// The longest quiet stretch in a correct run is a sender gap plus the
	// pipeline plus the settle pause, well within this limit.
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [0:0] operation = '0;
	logic [CH_W-1:0] channel = '0;
	logic [SLOT_W-1:0] slot = '0;
	logic [X_W-1:0] point_x = '0;
	logic signed [Y_W-1:0] point_y = '0;
	logic [IDX_W-1:0] sample_index = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CH_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic result_strobe;
	logic [OUT_W-1:0] red;
	logic [OUT_W-1:0] green;
	logic [OUT_W-1:0] blue;
	logic [OUT_W-1:0] alpha;
	logic [IDX_W-1:0] sample_echo;

	int error_count;
	int pending_count;

	// Requests accepted so far, and whether the current phase runs without gaps.
	int issued = 0;
	bit steady = 1'b0;
	// Which control points have been loaded. A sample may only be requested
	// once every point in use on every polyline holds a loaded value, since
	// the contents of the point store are undefined until written.
	bit written [CHANNELS][MAX_POINTS];
	// Shadow of the point-count registers as the stimulus last wrote them.
	int lane_points [CHANNELS] = '{3, 3, 3, 2};
	int quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	piecewise_linear_rgba_ramp i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.channel(channel),
		.slot(slot),
		.point_x(point_x),
		.point_y(point_y),
		.sample_index(sample_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.sample_echo(sample_echo)
	);

	plr_ramp_checker u_ramp_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.channel(channel),
		.slot(slot),
		.point_x(point_x),
		.point_y(point_y),
		.sample_index(sample_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.sample_echo(sample_echo),
		.error_count(error_count),
		.pending_count(pending_count)
	);

	// The watchdog restarts whenever anything moves on any channel.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || result_strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Effective number of points on a polyline: the block treats counts below
	// two as two and counts above the store size as the store size.
	function automatic int used_points(int ch);
		if (lane_points[ch] < 2)
			return 2;
		if (lane_points[ch] > MAX_POINTS)
			return MAX_POINTS;
		return lane_points[ch];
	endfunction

	function automatic bit polyline_loaded(int ch);
		for (int k = 0; k < used_points(ch); k++) begin
			if (!written[ch][k])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Mostly values inside 0..1.0, some over the full signed range (which
	// drives the clamp at both ends), and now and then an exact extreme.
	function automatic int pick_ordinate();
		case ($urandom_range(0, 9))
			7, 8: return int'($urandom_range(0, 262143)) - 131072;
			9: begin
				case ($urandom_range(0, 3))
					0: return -131072;
					1: return 131071;
					2: return 0;
					default: return ONE_Q16 - 1;
				endcase
			end
			default: return $urandom_range(0, ONE_Q16);
		endcase
	endfunction

	// Counts include the out-of-range values on both sides, which the block
	// must fold back to two or to the store size.
	function automatic int pick_count();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 0;
					1: return 1;
					2: return MAX_POINTS + 1;
					default: return 31;
				endcase
			end
			1: return MAX_POINTS;
			2: return 2;
			default: return $urandom_range(2, MAX_POINTS);
		endcase
	endfunction

	function automatic int pick_index();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return SAMPLE_COUNT - 1;
			default: return $urandom_range(0, SAMPLE_COUNT - 1);
		endcase
	endfunction

	// Presents one request and holds it until the block takes it. The sender
	// may first sit idle for a random number of cycles, unless the phase is a
	// back-to-back one. Each call runs in the time step of a rising edge, and
	// start gets exactly one assignment there, so a request that follows
	// directly keeps start high without a glitch.
	task automatic send_request(input logic op, input int ch, input int pos,
			input logic [X_W-1:0] x, input logic signed [Y_W-1:0] y,
			input logic [IDX_W-1:0] idx);
		int gap;
		gap = steady ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		channel <= CH_W'(ch);
		slot <= SLOT_W'(pos);
		point_x <= x;
		point_y <= y;
		sample_index <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
		issued++;
		if (op == OP_LOAD)
			written[ch][pos] = 1'b1;
	endtask

	// The sample index of a load request is a don't-care, so it is random.
	task automatic load_point(int ch, int pos, int x, int y);
		send_request(OP_LOAD, ch, pos, X_W'(x), Y_W'(y), IDX_W'($urandom));
	endtask

	// Point fields of a sample request are don't-cares and are randomized.
	task automatic take_sample(int idx);
		send_request(OP_SAMPLE, $urandom_range(0, CHANNELS - 1), $urandom_range(0, MAX_POINTS - 1),
			X_W'($urandom), Y_W'($urandom), IDX_W'(idx));
	endtask

	// A raw point write anywhere, with x over its whole 17-bit range. These
	// break the ordering of a polyline and push x beyond 1.0.
	task automatic noise_load();
		send_request(OP_LOAD, $urandom_range(0, CHANNELS - 1), $urandom_range(0, MAX_POINTS - 1),
			X_W'($urandom), Y_W'($urandom), IDX_W'($urandom));
	endtask

	// Loads a complete, sorted polyline over every point in use on a channel.
	// Interior abscissas are often snapped to a coarse grid so that repeated x
	// (zero-width segments) and segment ends that land exactly on a sample
	// position come up regularly. Occasionally the ends are pulled inward so
	// that samples fall before the first point or past the last one.
	task automatic load_polyline(int ch);
		int n;
		int xs [$];
		n = used_points(ch);
		for (int k = 0; k < n - 2; k++) begin
			if ($urandom_range(0, 2) == 0)
				xs.insert(xs.size(), int'($urandom_range(0, 16) * 4096));
			else
				xs.insert(xs.size(), int'($urandom_range(0, ONE_Q16)));
		end
		xs.insert(xs.size(),
			int'(($urandom_range(0, 7) == 0) ? $urandom_range(0, ONE_Q16 / 2) : 0));
		xs.insert(xs.size(),
			int'(($urandom_range(0, 7) == 0) ? $urandom_range(ONE_Q16 / 2, ONE_Q16) : ONE_Q16));
		xs.sort();
		for (int k = 0; k < n; k++)
			load_point(ch, k, xs[k], pick_ordinate());
	endtask

	// Stops sending and waits until every sample result has come back, then
	// lets the pipeline run empty. The first edge is always taken, because the
	// checker's pending count is registered and lags the request it counts.
	task automatic quiesce();
		start <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one point-count register. The caller lowers cfg_valid after the
	// last write of a batch, so back-to-back writes keep it high throughout.
	task automatic write_count(int ch, int value);
		cfg_valid <= 1'b1;
		cfg_index <= CH_W'(ch);
		cfg_data <= CNT_W'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		lane_points[ch] = value;
	endtask

	initial begin
		int first_random;
		int pick;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, with the counts the block comes out of reset with
		// (three points on red, green and blue, two on alpha).
		// Red is a triangle peaking at the center.
		load_point(CH_RED, 0, 0, 0);
		load_point(CH_RED, 1, ONE_Q16 / 2, ONE_Q16);
		load_point(CH_RED, 2, ONE_Q16, 0);
		// Green starts with a zero-width segment whose start y of 1.5 must
		// clamp high; after it the line climbs from -1.0 to 1.0.
		load_point(CH_GREEN, 0, 0, 98304);
		load_point(CH_GREEN, 1, 0, -ONE_Q16);
		load_point(CH_GREEN, 2, ONE_Q16, ONE_Q16);
		// Blue is unsorted: the first segment runs backward, sample zero lies
		// before it, and late samples lie past the end of the last segment.
		load_point(CH_BLUE, 0, 49152, ONE_Q16);
		load_point(CH_BLUE, 1, 16384, 0);
		load_point(CH_BLUE, 2, 40000, 131071);
		// Alpha spans the extremes of both fields, with x beyond 1.0.
		load_point(CH_ALPHA, 0, 0, -131072);
		load_point(CH_ALPHA, 1, 131071, 131071);
		take_sample(0);
		take_sample(1);
		take_sample(SAMPLE_COUNT / 4);
		take_sample(SAMPLE_COUNT / 2);
		take_sample(SAMPLE_COUNT - 1);
		// Counts below two must behave as two: red then extrapolates its
		// rising first segment, green sits on its zero-width segment.
		quiesce();
		write_count(CH_RED, 0);
		write_count(CH_GREEN, 1);
		cfg_valid <= 1'b0;
		take_sample(100);
		take_sample(200);

		// Random part, in phases. Each phase starts from an idle block, so the
		// count registers can be rewritten: all at the store size first, then
		// all at the minimum, then random values including out-of-range ones.
		first_random = issued;
		for (int phase = 0; issued < first_random + ITEM_TARGET; phase++) begin
			quiesce();
			steady = ($urandom_range(0, 3) == 0);
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (phase == 0)
					write_count(ch, MAX_POINTS);
				else if (phase == 1)
					write_count(ch, 2);
				else if ($urandom_range(0, 2) == 0)
					write_count(ch, pick_count());
			end
			cfg_valid <= 1'b0;
			// A count that grew may reach points never loaded; fill those
			// polylines before any sample can read them.
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (!polyline_loaded(ch))
					load_polyline(ch);
			end
			if ($urandom_range(0, 1) == 0)
				load_polyline($urandom_range(0, CHANNELS - 1));
			// Mostly samples over well-formed ramps, with whole ramps replaced
			// now and then and a sprinkling of stray point writes.
			repeat ($urandom_range(20, 120)) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					take_sample(pick_index());
				else if (pick < 86)
					load_polyline($urandom_range(0, CHANNELS - 1));
				else
					noise_load();
			end
		end

		quiesce();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
rtl/plr_pkg.sv
rtl/plr_point_store.sv
rtl/plr_lerp.sv
rtl/plr_divider.sv
rtl/piecewise_linear_rgba_ramp.sv
tb/plr_ramp_checker.sv
tb/tb.sv
